FILE: hdl/aspect_fit_nearest_downscaler_assert.svh
// Assertion macros used by the checker file.
// Both expect signals named clk and rst in the scope of use.
`ifndef ASPECT_FIT_NEAREST_DOWNSCALER_ASSERT_SVH
`define ASPECT_FIT_NEAREST_DOWNSCALER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/afd_pkg.sv
`default_nettype none

package afd_pkg;

  // Field widths
  localparam int DIM_W      = 13;
  localparam int PROD_W     = 2 * DIM_W;
  localparam int POS_W      = 16;
  localparam int PIX_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_FLD_W   = 2 * DIM_W + PIX_W;
  localparam int IN_DATA_W  = ((IN_FLD_W + 7) / 8) * 8;
  localparam int OUT_FLD_W  = 1 + 2 * DIM_W + 2 * POS_W + PIX_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int DIV_CNT_W  = $clog2(PROD_W);

  localparam int DEF_MAX_DIM = 4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd3;

  // Item kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // Status codes
  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_UNSUPPORTED = 1'b1;

  typedef enum logic [1:0] {
    DIV_FIT = 2'd0,
    DIV_COL = 2'd1,
    DIV_ROW = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     hdr;
    logic     pixel;
    logic     mul;
    logic     keep;
    logic     fit_done;
    logic     col_done;
    logic     row_done;
    logic     emit;
    logic     div_start;
    div_sel_t div_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hdr_bad;
    logic need_scale;
    logic div_done;
  } dp_stat_t;

  typedef struct packed {
    logic                    result_kind;
    logic                    status;
    logic [DIM_W-1:0]        fit_width;
    logic [DIM_W-1:0]        fit_height;
    logic signed [POS_W-1:0] draw_x;
    logic signed [POS_W-1:0] draw_y;
    logic [PIX_W-1:0]        out_pixel;
    logic                    last;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/afd_div.sv
`default_nettype none

// Restoring shift-subtract divider, one quotient bit per cycle.
module afd_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [afd_pkg::PROD_W-1:0] dividend,
  input  wire logic [afd_pkg::DIM_W-1:0]  divisor,
  output logic                            done,
  output logic      [afd_pkg::PROD_W-1:0] quotient,
  output logic      [afd_pkg::DIM_W-1:0]  remainder
);

  localparam logic [afd_pkg::DIV_CNT_W-1:0] LAST_STEP =
    afd_pkg::DIV_CNT_W'(afd_pkg::PROD_W - 1);

  logic                            busy;
  logic [afd_pkg::DIV_CNT_W-1:0]   cnt;
  logic [afd_pkg::PROD_W-1:0]      quo;
  logic [afd_pkg::DIM_W-1:0]       rem;
  logic [afd_pkg::DIM_W-1:0]       dvs;
  logic [afd_pkg::DIM_W:0]         rem_sh;
  logic [afd_pkg::DIM_W:0]         rem_sub;
  logic                            ge;

  // Shift in next dividend bit, try a subtract
  assign rem_sh  = {rem, quo[afd_pkg::PROD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + afd_pkg::DIV_CNT_W'(1);
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[afd_pkg::PROD_W-2:0], ge};
      rem <= ge ? rem_sub[afd_pkg::DIM_W-1:0] : rem_sh[afd_pkg::DIM_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

FILE: hdl/afd_dp.sv
`default_nettype none

// Datapath: box registers, fit arithmetic, raster counters and pixel selection.
module afd_dp #(
  parameter int MAX_DIM = afd_pkg::DEF_MAX_DIM
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wen,
  input  wire logic [afd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [afd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [afd_pkg::IN_FLD_W-1:0]   in_data,
  input  wire afd_pkg::ctrl_cmd_t             cmd,
  output afd_pkg::dp_stat_t                   stat,
  output logic                                res_valid,
  output afd_pkg::res_t                       res
);

  localparam int DW = afd_pkg::DIM_W;
  localparam int PW = afd_pkg::PROD_W;

  // Config registers
  logic signed [afd_pkg::POS_W-1:0] box_x;
  logic signed [afd_pkg::POS_W-1:0] box_y;
  logic [DW-1:0] box_w;
  logic [DW-1:0] box_h;

  // Image geometry
  logic [DW-1:0] sw_r, sh_r, tw, th;
  logic [PW-1:0] p_a, p_b;
  logic          le_r, bad_r, need_scale_r;
  logic [DW-1:0] col_q, col_r, row_q, row_r;

  // Raster state
  logic          active;
  logic [DW-1:0] src_row, src_col, tgt_row, tgt_col;
  logic [DW-1:0] nsr, nsr_rem, nsc, nsc_rem;

  // Input fields
  logic [DW-1:0]               in_sw, in_sh;
  logic [afd_pkg::PIX_W-1:0]   in_px;

  logic [DW-1:0] bw, bh;
  logic          le_now;

  // Divider hookup
  logic [PW-1:0] div_dvd;
  logic [DW-1:0] div_dvs;
  logic          div_done;
  logic [PW-1:0] div_q;
  logic [DW-1:0] div_r;
  logic [DW-1:0] q_fit;

  // Pixel selection
  logic          row_sel, col_sel, pix_hit, px_last, col_wrap;
  logic [DW-1:0] src_col_inc, src_row_inc;
  logic [DW:0]   c_sum, r_sum;
  logic          c_ovf, r_ovf;
  logic [DW-1:0] nsc_adv, nsc_rem_adv, nsr_adv, nsr_rem_adv;

  // Fit result
  logic [DW-1:0] diff_w, diff_h;
  afd_pkg::res_t fit_res, pix_res;

  function automatic logic [DW-1:0] clamp_box(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DW'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign in_sw = in_data[DW-1:0];
  assign in_sh = in_data[2*DW-1:DW];
  assign in_px = in_data[afd_pkg::IN_FLD_W-1:2*DW];

  assign bw = clamp_box(box_w);
  assign bh = clamp_box(box_h);

  assign stat.hdr_bad    = (in_sw == '0) || (in_sh == '0) ||
                           (32'(in_sw) > MAX_DIM) || (32'(in_sh) > MAX_DIM);
  assign stat.need_scale = need_scale_r;
  assign stat.div_done   = div_done;

  // Pick the divide operands
  assign le_now = p_a <= p_b;
  always_comb begin
    unique case (cmd.div_sel)
      afd_pkg::DIV_FIT: begin
        div_dvd = le_now ? p_a : p_b;
        div_dvs = le_now ? sw_r : sh_r;
      end
      afd_pkg::DIV_COL: begin
        div_dvd = PW'(sw_r);
        div_dvs = tw;
      end
      afd_pkg::DIV_ROW: begin
        div_dvd = PW'(sh_r);
        div_dvs = th;
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  afd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Scaled dimension never drops below one
  assign q_fit = (div_q[DW-1:0] == '0) ? DW'(1) : div_q[DW-1:0];

  // Selection against the next picked row and column
  assign row_sel     = (src_row == nsr) && (tgt_row < th);
  assign col_sel     = row_sel && (tgt_col < tw) && (src_col == nsc);
  assign pix_hit     = cmd.pixel && active && col_sel;
  assign px_last     = (tgt_row + DW'(1) == th) && (tgt_col + DW'(1) == tw);
  assign src_col_inc = src_col + DW'(1);
  assign src_row_inc = src_row + DW'(1);
  assign col_wrap    = src_col_inc == sw_r;

  // Step picked column: quotient step plus carry out of the remainder
  assign c_sum       = {1'b0, nsc_rem} + {1'b0, col_r};
  assign c_ovf       = c_sum >= {1'b0, tw};
  assign nsc_adv     = nsc + col_q + DW'(c_ovf);
  assign nsc_rem_adv = c_ovf ? DW'(c_sum - {1'b0, tw}) : c_sum[DW-1:0];

  // Step picked row
  assign r_sum       = {1'b0, nsr_rem} + {1'b0, row_r};
  assign r_ovf       = r_sum >= {1'b0, th};
  assign nsr_adv     = nsr + row_q + DW'(r_ovf);
  assign nsr_rem_adv = r_ovf ? DW'(r_sum - {1'b0, th}) : r_sum[DW-1:0];

  // Build results
  assign diff_w = bw - tw;
  assign diff_h = bh - th;

  always_comb begin
    fit_res = '0;
    if (bad_r) begin
      fit_res.status = afd_pkg::STATUS_UNSUPPORTED;
    end else begin
      fit_res.status     = afd_pkg::STATUS_OK;
      fit_res.fit_width  = tw;
      fit_res.fit_height = th;
      fit_res.draw_x     = box_x + afd_pkg::POS_W'(diff_w >> 1);
      fit_res.draw_y     = box_y + afd_pkg::POS_W'(diff_h >> 1);
    end
    fit_res.result_kind = afd_pkg::KIND_HEADER;

    pix_res             = '0;
    pix_res.result_kind = afd_pkg::KIND_PIXEL;
    pix_res.out_pixel   = in_px;
    pix_res.last        = px_last;
  end

  assign res_valid = pix_hit || cmd.emit;
  assign res       = cmd.emit ? fit_res : pix_res;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      box_x <= '0;
      box_y <= '0;
      box_w <= DW'(1);
      box_h <= DW'(1);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        afd_pkg::REG_BOX_X:      box_x <= cfg_wdata;
        afd_pkg::REG_BOX_Y:      box_y <= cfg_wdata;
        afd_pkg::REG_BOX_WIDTH:  box_w <= cfg_wdata[DW-1:0];
        afd_pkg::REG_BOX_HEIGHT: box_h <= cfg_wdata[DW-1:0];
        default: ;
      endcase
    end
  end

  // Geometry set up during a header
  always_ff @(posedge clk) begin
    if (cmd.hdr) begin
      sw_r         <= in_sw;
      sh_r         <= in_sh;
      bad_r        <= stat.hdr_bad;
      need_scale_r <= (in_sw > bw) || (in_sh > bh);
    end
    if (cmd.mul) begin
      p_a <= PW'(bw) * PW'(sh_r);
      p_b <= PW'(bh) * PW'(sw_r);
    end
    if (cmd.div_start && (cmd.div_sel == afd_pkg::DIV_FIT)) begin
      le_r <= le_now;
    end
    if (cmd.keep) begin
      tw <= sw_r;
      th <= sh_r;
    end
    if (cmd.fit_done) begin
      if (le_r) begin
        tw <= bw;
        th <= q_fit;
      end else begin
        tw <= q_fit;
        th <= bh;
      end
    end
    if (cmd.col_done) begin
      col_q <= div_q[DW-1:0];
      col_r <= div_r;
    end
    if (cmd.row_done) begin
      row_q <= div_q[DW-1:0];
      row_r <= div_r;
    end
  end

  // Raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      src_row <= '0;
      src_col <= '0;
      tgt_row <= '0;
      tgt_col <= '0;
      nsr     <= '0;
      nsr_rem <= '0;
      nsc     <= '0;
      nsc_rem <= '0;
    end else if (cmd.hdr) begin
      active <= 1'b0;
    end else if (cmd.emit) begin
      active  <= !bad_r;
      src_row <= '0;
      src_col <= '0;
      tgt_row <= '0;
      tgt_col <= '0;
      nsr     <= '0;
      nsr_rem <= '0;
      nsc     <= '0;
      nsc_rem <= '0;
    end else if (cmd.pixel && active) begin
      // End of a picked row restarts the column walk, else step the column
      if (col_wrap && row_sel) begin
        tgt_row <= tgt_row + DW'(1);
        tgt_col <= '0;
        nsc     <= '0;
        nsc_rem <= '0;
        nsr     <= nsr_adv;
        nsr_rem <= nsr_rem_adv;
      end else if (col_sel) begin
        tgt_col <= tgt_col + DW'(1);
        nsc     <= nsc_adv;
        nsc_rem <= nsc_rem_adv;
      end
      if (col_wrap) begin
        src_col <= '0;
        src_row <= src_row_inc;
        if (src_row_inc == sh_r) begin
          active <= 1'b0;
        end
      end else begin
        src_col <= src_col_inc;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/afd_ctrl.sv
`default_nettype none

// Controller: takes items, sequences the header arithmetic, posts the fit result.
module afd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  input  wire logic               kind,
  input  wire afd_pkg::dp_stat_t  stat,
  input  wire logic               ob_room,
  output logic                    s_tready,
  output afd_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL  = 8'b0000_0010,
    ST_CMP  = 8'b0000_0100,
    ST_DFIT = 8'b0000_1000,
    ST_CGO  = 8'b0001_0000,
    ST_DCOL = 8'b0010_0000,
    ST_DROW = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE) && ob_room;
  assign accept   = s_tvalid && s_tready;

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = afd_pkg::DIV_FIT;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (kind == afd_pkg::KIND_PIXEL) begin
            cmd.pixel = 1'b1;
          end else begin
            cmd.hdr    = 1'b1;
            state_next = stat.hdr_bad ? ST_EMIT : ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (stat.need_scale) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = afd_pkg::DIV_FIT;
          state_next    = ST_DFIT;
        end else begin
          cmd.keep   = 1'b1;
          state_next = ST_CGO;
        end
      end
      ST_DFIT: begin
        if (stat.div_done) begin
          cmd.fit_done = 1'b1;
          state_next   = ST_CGO;
        end
      end
      ST_CGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = afd_pkg::DIV_COL;
        state_next    = ST_DCOL;
      end
      ST_DCOL: begin
        cmd.div_sel = afd_pkg::DIV_ROW;
        if (stat.div_done) begin
          cmd.col_done  = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = ST_DROW;
        end
      end
      ST_DROW: begin
        if (stat.div_done) begin
          cmd.row_done = 1'b1;
          state_next   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (ob_room) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/afd_obuf.sv
`default_nettype none

// Output register with one skid slot, so a single waiting result does not stall input.
module afd_obuf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire afd_pkg::res_t  in_res,
  output logic                room,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output afd_pkg::res_t       m_res
);

  logic          out_v;
  logic          skid_v;
  afd_pkg::res_t skid;
  logic          load;

  assign load     = !out_v || m_tready;
  assign room     = !skid_v;
  assign m_tvalid = out_v;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (load) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= in_valid;
      end
    end else if (in_valid) begin
      skid_v <= 1'b1;
    end
  end

  // Payload: refill from skid first, else park the new beat
  always_ff @(posedge clk) begin
    if (load) begin
      m_res <= skid_v ? skid : in_res;
    end else if (in_valid) begin
      skid <= in_res;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/aspect_fit_nearest_downscaler.sv
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tuser: kind; tdata: src_width, src_height, src_pixel
// m_*      out  tuser: result_kind; tlast: last;
//               tdata: status, fit_width, fit_height, draw_x, draw_y, out_pixel
// cfg_*    in   write only: box_x, box_y, box_w, box_h
//
// A pixel beat is taken while the controller is idle and the output has room; its
// result, if selected, is registered. A valid header runs the 26-step shift-subtract
// divider two or three times: a fit divide when scaled, then a column and a row divide;
// a header with an unsupported size goes straight to the emit state.
// rst is synchronous, active high; no clearing pass follows it.
// A result may wait in the output register while one more beat is taken.
`default_nettype none

module aspect_fit_nearest_downscaler #(
  parameter int MAX_DIM = afd_pkg::DEF_MAX_DIM
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // src_width [12:0], src_height [25:13], src_pixel [41:26], zero pad above
  input  wire logic [afd_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind [0]
  input  wire logic [0:0]                     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // status [0], fit_width [13:1], fit_height [26:14], draw_x [42:27],
  // draw_y [58:43], out_pixel [74:59], zero pad above
  output logic [afd_pkg::OUT_DATA_W-1:0]      m_tdata,
  // result_kind [0]
  output logic [0:0]                          m_tuser,
  output logic                                m_tlast,
  input  wire logic                           cfg_wen,
  input  wire logic [afd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [afd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  afd_pkg::ctrl_cmd_t cmd;
  afd_pkg::dp_stat_t  stat;
  afd_pkg::res_t      res;
  afd_pkg::res_t      m_res;
  logic               res_valid;
  logic               ob_room;

  afd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (s_tuser[0]),
    .stat     (stat),
    .ob_room  (ob_room),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  afd_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_tdata[afd_pkg::IN_FLD_W-1:0]),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res       (res)
  );

  afd_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_res   (res),
    .room     (ob_room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  // Pack result beat
  assign m_tdata = afd_pkg::OUT_DATA_W'({m_res.out_pixel, m_res.draw_y, m_res.draw_x,
                                         m_res.fit_height, m_res.fit_width,
                                         m_res.status});
  assign m_tuser = m_res.result_kind;
  assign m_tlast = m_res.last;

endmodule

`default_nettype wire

FILE: hdl/afd_checker.sv
`default_nettype none

`include "aspect_fit_nearest_downscaler_assert.svh"

// Port-level checks on the downscaler.
module afd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [0:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata,
  input wire logic [0:0]  m_tuser,
  input wire logic        m_tlast
);

  // Stalled result beat holds
  `AFD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

  // Fit results never carry last
  `AFD_ASSERT_SAME(a_fit_nolast, m_tvalid && !m_tuser[0], !m_tlast, "fit result with last set")

  // Pixel results carry only the pixel field
  `AFD_ASSERT_SAME(a_pix_clean, m_tvalid && m_tuser[0], (m_tdata[58:0] == '0) && (m_tdata[79:75] == '0), "pixel result has fit fields")

  // Accepted header makes the block busy next cycle
  `AFD_ASSERT_NEXT(a_hdr_busy, s_tvalid && s_tready && !s_tuser[0], !s_tready, "ready right after header")

  // A good fit is never empty
  `AFD_ASSERT_SAME(a_fit_size, m_tvalid && !m_tuser[0] && !m_tdata[0], (m_tdata[13:1] != '0) && (m_tdata[26:14] != '0), "ok fit with zero size")

endmodule

bind aspect_fit_nearest_downscaler afd_checker u_afd_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_SIDE      = afd_pkg::DEF_MAX_DIM;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int TOTAL_BEATS   = 1900;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  // src_width [12:0], src_height [25:13], src_pixel [41:26], zero pad above
  logic [afd_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  // kind [0]
  logic [0:0]                     s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // status [0], fit_width [13:1], fit_height [26:14], draw_x [42:27],
  // draw_y [58:43], out_pixel [74:59], zero pad above
  logic [afd_pkg::OUT_DATA_W-1:0] m_tdata;
  // result_kind [0]
  logic [0:0]                     m_tuser;
  logic                           m_tlast;
  logic                           cfg_wen = 1'b0;
  logic [afd_pkg::CFG_IDX_W-1:0]  cfg_index = afd_pkg::REG_BOX_X;
  logic [afd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow of the box registers
  logic [afd_pkg::POS_W-1:0] box_left = '0;
  logic [afd_pkg::POS_W-1:0] box_top = '0;
  int unsigned               box_w_reg = 1;
  int unsigned               box_h_reg = 1;

  // Shadow of the image walk
  bit          img_on = 1'b0;
  int unsigned src_w = 0, src_h = 0, fit_w = 0, fit_h = 0;
  int unsigned src_row = 0, src_col = 0, out_row = 0, out_col = 0;
  int unsigned want_row = 0, want_col = 0;

  afd_pkg::res_t fit_pixel_q[$];
  int unsigned   errors = 0;
  int unsigned   sent_beats = 0;
  int unsigned   cycle_count = 0;
  bit            gaps_on = 1'b1;
  int unsigned   hold_token = 0;

  aspect_fit_nearest_downscaler u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned box_side(int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  // Source index feeding output index t: floor(t * source / fitted)
  function automatic int unsigned nearest_index(int unsigned t, int unsigned s,
                                                int unsigned fitted);
    if (fitted == 0) return 0;
    return (t * s) / fitted;
  endfunction

  // Work out the result of one accepted beat and queue it, if there is one
  function automatic void predict_downscale(logic kind, int unsigned w, int unsigned h,
                                            logic [afd_pkg::PIX_W-1:0] px);
    afd_pkg::res_t r;
    int unsigned   bw, bh, tw, th;
    bit            row_hit;
    r = '0;
    if (kind == afd_pkg::KIND_HEADER) begin
      bw = box_side(box_w_reg);
      bh = box_side(box_h_reg);
      img_on = 1'b0;
      r.result_kind = afd_pkg::KIND_HEADER;
      if (w == 0 || h == 0 || w > MAX_SIDE || h > MAX_SIDE) begin
        r.status = afd_pkg::STATUS_UNSUPPORTED;
      end else begin
        tw = w;
        th = h;
        // Shrink only; pick the axis that limits the fit
        if (w > bw || h > bh) begin
          if (bw * h <= bh * w) begin
            th = (h * bw) / w;
            tw = bw;
          end else begin
            tw = (w * bh) / h;
            th = bh;
          end
          if (tw == 0) tw = 1;
          if (th == 0) th = 1;
        end
        src_w = w;
        src_h = h;
        fit_w = tw;
        fit_h = th;
        src_row = 0;
        src_col = 0;
        out_row = 0;
        out_col = 0;
        want_row = 0;
        want_col = 0;
        img_on = 1'b1;
        r.status = afd_pkg::STATUS_OK;
        r.fit_width = tw[afd_pkg::DIM_W-1:0];
        r.fit_height = th[afd_pkg::DIM_W-1:0];
        r.draw_x = box_left + afd_pkg::POS_W'((bw - tw) >> 1);
        r.draw_y = box_top + afd_pkg::POS_W'((bh - th) >> 1);
      end
      fit_pixel_q.push_back(r);
      return;
    end
    if (!img_on) return;
    row_hit = (src_row == want_row) && (out_row < fit_h);
    if (row_hit && out_col < fit_w && src_col == want_col) begin
      r.result_kind = afd_pkg::KIND_PIXEL;
      r.out_pixel = px;
      r.last = (out_row + 1 == fit_h) && (out_col + 1 == fit_w);
      fit_pixel_q.push_back(r);
      out_col++;
      want_col = nearest_index(out_col, src_w, fit_w);
    end
    // Advance the raster position
    src_col++;
    if (src_col >= src_w) begin
      src_col = 0;
      src_row++;
      if (row_hit) begin
        out_row++;
        out_col = 0;
        want_col = 0;
        want_row = nearest_index(out_row, src_h, fit_h);
      end
      if (src_row >= src_h) img_on = 1'b0;
    end
  endfunction

  // Offer one beat from a falling edge; valid stays high on return
  task automatic send_beat(input logic kind, input logic [afd_pkg::DIM_W-1:0] w,
                           input logic [afd_pkg::DIM_W-1:0] h,
                           input logic [afd_pkg::PIX_W-1:0] px);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 30) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {{(afd_pkg::IN_DATA_W - afd_pkg::IN_FLD_W){1'b0}}, px, h, w};
    do @(posedge clk); while (!s_tready);
    sent_beats++;
    predict_downscale(kind, w, h, px);
    @(negedge clk);
  endtask

  task automatic send_header(input int unsigned w, input int unsigned h);
    send_beat(afd_pkg::KIND_HEADER, afd_pkg::DIM_W'(w), afd_pkg::DIM_W'(h),
              afd_pkg::PIX_W'($urandom()));
  endtask

  task automatic send_pixel(input logic [afd_pkg::PIX_W-1:0] px);
    send_beat(afd_pkg::KIND_PIXEL, afd_pkg::DIM_W'($urandom()),
              afd_pkg::DIM_W'($urandom()), px);
  endtask

  task automatic send_image(input int unsigned w, input int unsigned h,
                            input int unsigned n_px);
    send_header(w, h);
    repeat (n_px) send_pixel(afd_pkg::PIX_W'($urandom()));
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (fit_pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write all four box registers while the block is idle
  task automatic set_box(input logic [afd_pkg::POS_W-1:0] x,
                         input logic [afd_pkg::POS_W-1:0] y,
                         input logic [afd_pkg::DIM_W-1:0] w,
                         input logic [afd_pkg::DIM_W-1:0] h);
    wait_for_results();
    cfg_wen <= 1'b1;
    cfg_index <= afd_pkg::REG_BOX_X;
    cfg_wdata <= x;
    @(negedge clk);
    cfg_index <= afd_pkg::REG_BOX_Y;
    cfg_wdata <= y;
    @(negedge clk);
    cfg_index <= afd_pkg::REG_BOX_WIDTH;
    cfg_wdata <= afd_pkg::CFG_DATA_W'(w);
    @(negedge clk);
    cfg_index <= afd_pkg::REG_BOX_HEIGHT;
    cfg_wdata <= afd_pkg::CFG_DATA_W'(h);
    @(negedge clk);
    cfg_wen <= 1'b0;
    box_left = x;
    box_top = y;
    box_w_reg = w;
    box_h_reg = h;
  endtask

  function automatic logic [afd_pkg::DIM_W-1:0] random_box_side();
    unique case ($urandom_range(0, 9))
      0: return '0;
      1: return afd_pkg::DIM_W'(MAX_SIDE);
      2: return afd_pkg::DIM_W'($urandom_range(MAX_SIDE + 1, (1 << afd_pkg::DIM_W) - 1));
      default: return afd_pkg::DIM_W'($urandom_range(1, 16));
    endcase
  endfunction

  // Box at reset is 1x1: bad sizes, floor to one, drop and surplus pixels
  task automatic test_default_box();
    send_pixel(16'hFFFF);
    send_header(0, 5);
    send_header(5, 0);
    send_header(MAX_SIDE + 1, 4);
    send_header((1 << afd_pkg::DIM_W) - 1, (1 << afd_pkg::DIM_W) - 1);
    send_header(MAX_SIDE, 3);
    send_header(MAX_SIDE, MAX_SIDE);
    send_pixel(16'h0000);
    // New header while an image is in flight
    send_image(3, 3, 2);
    send_image(2, 1, 2);
    send_pixel(16'hA5A5);
  endtask

  // Position wrap at both ends, zero and oversize box sides
  task automatic test_box_extremes();
    set_box(16'h7FFF, 16'h8000, afd_pkg::DIM_W'(MAX_SIDE), afd_pkg::DIM_W'(MAX_SIDE));
    send_image(2, 2, 4);
    set_box(16'h8000, 16'h7FFF, '0, afd_pkg::DIM_W'((1 << afd_pkg::DIM_W) - 1));
    send_image(3, 1, 3);
  endtask

  // Hold the output off while pixels keep coming, then pause until drained
  task automatic test_output_stall();
    set_box(16'd100, 16'd50, 13'd64, 13'd64);
    hold_token++;
    send_image(8, 8, 64);
    wait_for_results();
  endtask

  task automatic test_random_images();
    int unsigned phase;
    int unsigned w, h, t, pick;
    phase = 0;
    while (sent_beats < TOTAL_BEATS) begin
      set_box(afd_pkg::POS_W'($urandom()), afd_pkg::POS_W'($urandom()),
              random_box_side(), random_box_side());
      // One phase in four runs with no gaps on either side
      gaps_on = (phase % 4 != 2);
      repeat ($urandom_range(4, 10)) begin
        if (sent_beats >= TOTAL_BEATS) break;
        pick = $urandom_range(0, 99);
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 12);
        if ($urandom_range(0, 7) == 0) begin
          w = $urandom_range(13, 48);
          h = $urandom_range(1, 4);
        end
        if ($urandom_range(0, 1) == 1) begin
          t = w;
          w = h;
          h = t;
        end
        if (pick < 70) begin
          send_image(w, h, w * h);
        end else if (pick < 80) begin
          send_image(w, h, $urandom_range(0, w * h - 1));
        end else if (pick < 88) begin
          send_image($urandom_range(1024, MAX_SIDE), $urandom_range(1024, MAX_SIDE),
                     $urandom_range(1, 24));
        end else if (pick < 94) begin
          w = ($urandom_range(0, 1) == 1) ? 0 :
              $urandom_range(MAX_SIDE + 1, (1 << afd_pkg::DIM_W) - 1);
          h = $urandom_range(0, (1 << afd_pkg::DIM_W) - 1);
          if ($urandom_range(0, 1) == 1) send_header(w, h);
          else send_header(h, w);
        end else begin
          repeat ($urandom_range(1, 4)) send_pixel(afd_pkg::PIX_W'($urandom()));
        end
      end
      phase++;
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(gaps_on && $urandom_range(0, 99) < 30);
      end
    end
  end

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Check each result beat against the oldest expectation
  afd_pkg::res_t got_res, want_res;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res.result_kind = m_tuser[0];
      got_res.status      = m_tdata[0];
      got_res.fit_width   = m_tdata[13:1];
      got_res.fit_height  = m_tdata[26:14];
      got_res.draw_x      = m_tdata[42:27];
      got_res.draw_y      = m_tdata[58:43];
      got_res.out_pixel   = m_tdata[74:59];
      got_res.last        = m_tlast;
      if (fit_pixel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got_res);
      end else begin
        want_res = fit_pixel_q.pop_front();
        compare_field("result_kind", want_res.result_kind, got_res.result_kind);
        compare_field("status", want_res.status, got_res.status);
        compare_field("fit_width", want_res.fit_width, got_res.fit_width);
        compare_field("fit_height", want_res.fit_height, got_res.fit_height);
        compare_field("draw_x", want_res.draw_x, got_res.draw_x);
        compare_field("draw_y", want_res.draw_y, got_res.draw_y);
        compare_field("out_pixel", want_res.out_pixel, got_res.out_pixel);
        compare_field("last", want_res.last, got_res.last);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_default_box();
    test_box_extremes();
    test_output_stall();
    test_random_images();
    wait_for_results();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/afd_pkg.sv
hdl/afd_div.sv
hdl/afd_dp.sv
hdl/afd_ctrl.sv
hdl/afd_obuf.sv
hdl/aspect_fit_nearest_downscaler.sv
hdl/afd_checker.sv
bench/tb_top.sv
